### design/pef_pkg.sv
// ----------------------------------------------------------------------------
// Prewitt edge filter package
// Shared constants for the 3x3 Prewitt edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pef_pkg;

    localparam int MAX_DIM_DEF = 512;
    localparam int DIM_MIN     = 3;
    localparam int CFG_W       = 10;
    localparam int PIX_W       = 8;
    localparam int PIX_MAX     = 255;
    localparam int SCALE_SHIFT = 9;
    localparam int SUM_W       = 11;
    localparam int MAG_W       = 10;
    localparam int PROD_W      = MAG_W + PIX_W;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [1:0] REG_IMAGE_ROWS    = 2'd0;
    localparam logic [1:0] REG_IMAGE_COLS    = 2'd1;
    localparam logic [1:0] REG_VERTICAL_MODE = 2'd2;

endpackage

`default_nettype wire

### design/prewitt_edge_filter_3x3.sv
// ----------------------------------------------------------------------------
// Prewitt edge filter 3x3
// Streaming horizontal/vertical Prewitt edge magnitude over a raster image.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pixel's result passes stage s1, stage s2 and the result queue before it is valid.
// Throughput: 1 pixel per cycle while the result queue has room, set by the line memory
// read-modify-write (read at accept, write-back in the next cycle, forwarded on a same-entry hit).
// Reset: position counters, window and result queue clear; registers return
// to 512 rows, 512 columns, horizontal mode. Line memory is not cleared.
`default_nettype none

module prewitt_edge_filter_3x3 #(
    parameter int MAX_DIM = pef_pkg::MAX_DIM_DEF,
    parameter int DIM_W   = $clog2(MAX_DIM)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pef_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pef_pkg::DATA_W-1:0]   pwdata,
    output logic      [pef_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,

    input  wire logic                         pixel_valid,
    output logic                              pixel_ready,
    input  wire logic [pef_pkg::PIX_W-1:0]    pixel,
    input  wire logic                         frame_start,

    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic      [pef_pkg::PIX_W-1:0]    edge_value,
    output logic      [DIM_W-1:0]             row,
    output logic      [DIM_W-1:0]             col,
    output logic                              last_of_frame
);

    localparam int CNT_W  = DIM_W + 1;
    localparam int W_CMP  = (CNT_W > pef_pkg::CFG_W) ? CNT_W : pef_pkg::CFG_W;
    localparam int PIX_W  = pef_pkg::PIX_W;
    localparam int MEM_W  = 2 * PIX_W;
    localparam int SUM_W  = pef_pkg::SUM_W;
    localparam int MAG_W  = pef_pkg::MAG_W;
    localparam int PROD_W = pef_pkg::PROD_W;
    localparam int VAL_W  = PROD_W - pef_pkg::SCALE_SHIFT;
    localparam int DEPTH  = pef_pkg::FIFO_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FCNT_W = $clog2(DEPTH + 3);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pef_pkg::CFG_W-1:0] image_rows_reg;
    logic [pef_pkg::CFG_W-1:0] image_cols_reg;
    logic                      vertical_mode_reg;
    logic                      cfg_write;
    logic [1:0]                cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg    <= pef_pkg::CFG_W'(pef_pkg::MAX_DIM_DEF);
            image_cols_reg    <= pef_pkg::CFG_W'(pef_pkg::MAX_DIM_DEF);
            vertical_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                pef_pkg::REG_IMAGE_ROWS:    image_rows_reg    <= pwdata[pef_pkg::CFG_W-1:0];
                pef_pkg::REG_IMAGE_COLS:    image_cols_reg    <= pwdata[pef_pkg::CFG_W-1:0];
                pef_pkg::REG_VERTICAL_MODE: vertical_mode_reg <= pwdata[0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            pef_pkg::REG_IMAGE_ROWS:    prdata = pef_pkg::DATA_W'(image_rows_reg);
            pef_pkg::REG_IMAGE_COLS:    prdata = pef_pkg::DATA_W'(image_cols_reg);
            pef_pkg::REG_VERTICAL_MODE: prdata = pef_pkg::DATA_W'(vertical_mode_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective dimensions
    // ------------------------------------------------------------------
    logic [W_CMP-1:0] rows_ext;
    logic [W_CMP-1:0] cols_ext;
    logic [W_CMP-1:0] rows_clip;
    logic [W_CMP-1:0] cols_clip;
    logic [CNT_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;

    always_comb
    begin
        rows_ext = W_CMP'(image_rows_reg);
        cols_ext = W_CMP'(image_cols_reg);
        if (rows_ext < W_CMP'(pef_pkg::DIM_MIN))
            rows_clip = W_CMP'(pef_pkg::DIM_MIN);
        else if (rows_ext > W_CMP'(MAX_DIM))
            rows_clip = W_CMP'(MAX_DIM);
        else
            rows_clip = rows_ext;
        if (cols_ext < W_CMP'(pef_pkg::DIM_MIN))
            cols_clip = W_CMP'(pef_pkg::DIM_MIN);
        else if (cols_ext > W_CMP'(MAX_DIM))
            cols_clip = W_CMP'(MAX_DIM);
        else
            cols_clip = cols_ext;
        rows_eff = rows_clip[CNT_W-1:0];
        cols_eff = cols_clip[CNT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Position tracking at accept
    // ------------------------------------------------------------------
    logic             accept;
    logic [DIM_W-1:0] row_count_reg;
    logic [DIM_W-1:0] col_count_reg;
    logic [DIM_W-1:0] row_count_next;
    logic [DIM_W-1:0] col_count_next;
    logic [CNT_W-1:0] pre_row;
    logic [CNT_W-1:0] pre_col;
    logic [CNT_W-1:0] cur_row;
    logic [CNT_W-1:0] cur_col;
    logic [CNT_W-1:0] nxt_row;
    logic [CNT_W-1:0] nxt_col;
    logic             cur_emit;
    logic             cur_last;

    always_comb
    begin
        if (frame_start)
        begin
            pre_row = '0;
            pre_col = '0;
        end
        else
        begin
            pre_row = CNT_W'(row_count_reg);
            pre_col = CNT_W'(col_count_reg);
        end
        if (pre_col >= cols_eff)
        begin
            cur_col = '0;
            cur_row = pre_row + CNT_W'(1);
        end
        else
        begin
            cur_col = pre_col;
            cur_row = pre_row;
        end
        if (cur_row >= rows_eff)
            cur_row = '0;

        nxt_col = cur_col + CNT_W'(1);
        nxt_row = cur_row;
        if (nxt_col >= cols_eff)
        begin
            nxt_col = '0;
            nxt_row = cur_row + CNT_W'(1);
            if (nxt_row >= rows_eff)
                nxt_row = '0;
        end
        row_count_next = nxt_row[DIM_W-1:0];
        col_count_next = nxt_col[DIM_W-1:0];

        cur_emit = (cur_row >= CNT_W'(2)) && (cur_col >= CNT_W'(2));
        cur_last = (cur_row == rows_eff - CNT_W'(1)) && (cur_col == cols_eff - CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: {older row, previous row} per column
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] line_mem [MAX_DIM];
    logic [MEM_W-1:0] mem_q_reg;
    logic [MEM_W-1:0] fwd_data_reg;
    logic             fwd_reg;
    logic [MEM_W-1:0] rd_eff;
    logic [MEM_W-1:0] wr_data;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [DIM_W-1:0] s1_c_reg;
    logic [DIM_W-1:0] s1_row_reg;
    logic [DIM_W-1:0] s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;

    assign rd_eff  = fwd_reg ? fwd_data_reg : mem_q_reg;
    assign wr_data = {rd_eff[PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_c_reg] <= wr_data;
        if (accept)
            mem_q_reg <= line_mem[cur_col[DIM_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_reg      <= accept && s1_valid_reg && (s1_c_reg == cur_col[DIM_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wr_data;
            s1_pix_reg   <= pixel;
            s1_c_reg     <= cur_col[DIM_W-1:0];
            s1_row_reg   <= DIM_W'(cur_row - CNT_W'(1));
            s1_col_reg   <= DIM_W'(cur_col - CNT_W'(1));
            s1_emit_reg  <= cur_emit;
            s1_last_reg  <= cur_last;
        end
    end

    // ------------------------------------------------------------------
    // Window shift and template sum
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] new_col [3];
    logic [PIX_W-1:0] wn      [3][3];
    logic [SUM_W-1:0] sum_h;
    logic [SUM_W-1:0] sum_v;

    always_comb
    begin
        new_col[0] = rd_eff[MEM_W-1:PIX_W];
        new_col[1] = rd_eff[PIX_W-1:0];
        new_col[2] = s1_pix_reg;
        for (int k = 0; k < 3; k++)
        begin
            wn[k][0] = win_reg[k][1];
            wn[k][1] = win_reg[k][2];
            wn[k][2] = new_col[k];
        end
        sum_h = '0;
        sum_v = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum_h = sum_h + SUM_W'(wn[k][0]) - SUM_W'(wn[k][2]);
            sum_v = sum_v + SUM_W'(wn[0][k]) - SUM_W'(wn[2][k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= wn[i][j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Magnitude, scale and saturate
    // ------------------------------------------------------------------
    logic                    s2_valid_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic [DIM_W-1:0]        s2_row_reg;
    logic [DIM_W-1:0]        s2_col_reg;
    logic                    s2_last_reg;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [VAL_W-1:0]        scaled;
    logic [PIX_W-1:0]        edge_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_sum_reg  <= vertical_mode_reg ? sum_v : sum_h;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    always_comb
    begin
        if (s2_sum_reg < 0)
            mag = MAG_W'(-s2_sum_reg);
        else
            mag = MAG_W'(s2_sum_reg);
        prod   = (PROD_W'(mag) << PIX_W) - PROD_W'(mag);
        scaled = prod[PROD_W-1:pef_pkg::SCALE_SHIFT];
        if (scaled > VAL_W'(pef_pkg::PIX_MAX))
            edge_calc = PIX_W'(pef_pkg::PIX_MAX);
        else
            edge_calc = scaled[PIX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  q_edge [DEPTH];
    logic [DIM_W-1:0]  q_row  [DEPTH];
    logic [DIM_W-1:0]  q_col  [DEPTH];
    logic              q_last [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FCNT_W-1:0] fifo_count_reg;
    logic [FCNT_W-1:0] fifo_count_next;
    logic [FCNT_W-1:0] committed;
    logic              pop;

    assign committed    = fifo_count_reg + FCNT_W'(s1_valid_reg) + FCNT_W'(s2_valid_reg);
    assign pixel_ready  = committed < FCNT_W'(DEPTH);
    assign accept       = pixel_valid && pixel_ready;
    assign result_valid = fifo_count_reg != '0;
    assign pop          = result_valid && result_ready;

    assign edge_value    = q_edge[rd_ptr_reg];
    assign row           = q_row[rd_ptr_reg];
    assign col           = q_col[rd_ptr_reg];
    assign last_of_frame = q_last[rd_ptr_reg];

    always_comb
    begin
        fifo_count_next = fifo_count_reg + FCNT_W'(s2_valid_reg) - FCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            q_edge[wr_ptr_reg] <= edge_calc;
            q_row[wr_ptr_reg]  <= s2_row_reg;
            q_col[wr_ptr_reg]  <= s2_col_reg;
            q_last[wr_ptr_reg] <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fifo_count_reg <= fifo_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        committed <= FCNT_W'(DEPTH))
        else $error("result queue over-committed");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not enter the pipeline");

    a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg) && $past(s1_emit_reg))
        else $error("result stage valid without an emitting pixel");

    a_fwd_origin: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(s1_valid_reg) && $past(accept))
        else $error("forward taken without an overlapping write-back");

endmodule

`default_nettype wire
